>>> src/awir_pkg.sv
// ----------------------------------------------------------------------------
// awir_pkg
// Shared types and constants of the alpha weighted image resampler.
// ----------------------------------------------------------------------------
package awir_pkg;

   localparam int CFG_W     = 10;
   localparam int POS_W     = 9;
   localparam int CH_W      = 8;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_HEIGHT = 2'd3;

   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 10'd512;
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 10'd512;
   localparam logic [CFG_W-1:0] RST_TGT_WIDTH  = 10'd128;
   localparam logic [CFG_W-1:0] RST_TGT_HEIGHT = 10'd128;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [CH_W-1:0]  in_red;
      logic [CH_W-1:0]  in_green;
      logic [CH_W-1:0]  in_blue;
      logic [CH_W-1:0]  in_alpha;
   } awir_req_type;

   typedef struct packed {
      logic [CH_W-1:0] out_red;
      logic [CH_W-1:0] out_green;
      logic [CH_W-1:0] out_blue;
      logic [CH_W-1:0] out_alpha;
   } awir_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_FX,
      ST_DIV_FY,
      ST_DIV_RW,
      ST_DIV_RH,
      ST_AX_PREP,
      ST_DIV_AX,
      ST_CRN_BASE,
      ST_ACC,
      ST_DIV_A,
      ST_DIV_C,
      ST_CRN_END,
      ST_BLEND,
      ST_RESP
   } awir_state_type;

endpackage

>>> src/awir_frame_ram.sv
// ----------------------------------------------------------------------------
// awir_frame_ram
// Single port frame store, one word per pixel, registered read data.
// ----------------------------------------------------------------------------
module awir_frame_ram #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wdata,
   output logic [31:0]   rdata
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

>>> src/awir_divider.sv
// ----------------------------------------------------------------------------
// awir_divider
// Restoring divider, one quotient bit per cycle, done strobe at the end.
// ----------------------------------------------------------------------------
module awir_divider #(
   parameter int NUMW = 36,
   parameter int DENW = 28
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] num,
   input  logic [DENW-1:0] den,
   output logic            done,
   output logic [NUMW-1:0] quo
);

   localparam int CW = $clog2(NUMW + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic [DENW-1:0] den_ff, den_in;
   logic [DENW-1:0] rem_ff, rem_in;
   logic [DENW:0]   trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUMW-1]};
      ge      = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(NUMW);
         num_in = num;
         den_in = den;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[NUMW-2:0], ge};
         rem_in = ge ? DENW'(trial - {1'b0, den_ff}) : trial[DENW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

>>> src/alpha_weighted_image_resampler.sv
// ----------------------------------------------------------------------------
// alpha_weighted_image_resampler
// Frame store load, box prefilter with alpha weighting, bilinear resample.
//
//   channel  ports                              handshake
//   req      start, busy, req_word              start & !busy
//   rsp      rsp_valid, rsp_word                one-cycle strobe
//   csr      csr_valid, csr_ready, csr_index,   csr_valid & csr_ready
//            csr_data
//
// A pixel write never raises busy.
// A pixel request holds busy up to and including the cycle of its result
// strobe; a corner with zero alpha sum skips its three color divisions.
// The shared bit-serial divider and the one-read-per-cycle frame store
// set how long a request holds busy.
// Reset clears control state and loads the size registers with their reset values; the frame store is not cleared.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module alpha_weighted_image_resampler
   import awir_pkg::*;
#(
   parameter int MAX_SIDE = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  awir_req_type         req_word,
   output logic                 rsp_valid,
   output awir_rsp_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int ANW   = SW + POS_W + 1;
   localparam int AXNW  = ANW + FRAC_W;
   localparam int NSQW  = 2 * SW;
   localparam int SUMAW = 2 * SW + CH_W;
   localparam int SUMCW = 2 * SW + 2 * CH_W;
   localparam int NUMW  = (SUMCW > AXNW) ? SUMCW : AXNW;
   localparam int DENW  = (SUMAW > SW + 1) ? SUMAW : SW + 1;
   localparam int IPW   = NUMW - FRAC_W;

   function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [SW-1:0] r;
      if (v == '0) begin
         r = SW'(1);
      end else if (32'(v) > 32'(MAX_SIDE)) begin
         r = SW'(MAX_SIDE);
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   awir_state_type state_ff, state_in;

   logic [CFG_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [SW-1:0]    sw_c, sh_c, tw_c, th_c;

   logic             div_run_ff, div_run_in, div_start, div_done;
   logic [NUMW-1:0]  div_num, quo;
   logic [DENW-1:0]  div_den;

   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [SW-1:0]    qx_ff, qx_in, fac_ff, fac_in, rw_ff, rw_in, rh_ff, rh_in;
   logic             ax_y_ff, ax_y_in;
   logic [ANW-1:0]   anum_ff, anum_in;
   logic [SW-1:0]    x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [FRAC_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [1:0]       crn_ff, crn_in, ch_ff, ch_in;
   logic             ph_ff, ph_in;
   logic [SW-1:0]    colb_ff, colb_in, rowb_ff, rowb_in, xx_ff, xx_in, yy_ff, yy_in;
   logic [NSQW-1:0]  n_ff, n_in;
   logic             iss_done_ff, iss_done_in, rd_valid_ff, rd_valid_in;
   logic [SUMAW-1:0] suma_ff, suma_in;
   logic [SUMCW-1:0] sumc_ff [3];
   logic [SUMCW-1:0] sumc_in [3];
   logic [31:0]      raw_ff, raw_in;
   logic [31:0]      pix_ff [4];
   logic [31:0]      pix_in [4];
   logic [CH_W-1:0]  out_ff [4];
   logic [CH_W-1:0]  out_in [4];
   logic signed [26:0] top_ff, top_in, bot_ff, bot_in;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_addr;
   logic [31:0]      ram_q;
   logic             wr_in_range;

   logic [POS_W-1:0] ap;
   logic [SW-1:0]    as_c, at_c, smax, i0, i1, qy, fmin, cx, cy;
   logic [SW:0]      i0p;
   logic [IPW-1:0]   ip;
   logic [CH_W-1:0]  pa, pb, pd, pe;
   logic signed [8:0]  dab, dde;
   logic signed [16:0] txs, tys;
   logic signed [25:0] pab, pde;
   logic signed [26:0] dtb;
   logic signed [43:0] pv;
   logic signed [44:0] v;
   logic [43:0]      vu;
   logic [11:0]      vr;

   assign sw_c = clamp_side(src_w_ff);
   assign sh_c = clamp_side(src_h_ff);
   assign tw_c = clamp_side(tgt_w_ff);
   assign th_c = clamp_side(tgt_h_ff);

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = state_ff == ST_RESP;
   assign rsp_word  = '{out_red: out_ff[0], out_green: out_ff[1],
                        out_blue: out_ff[2], out_alpha: out_ff[3]};

   assign wr_in_range = (32'(req_word.pos_x) < 32'(MAX_SIDE)) &&
                        (32'(req_word.pos_y) < 32'(MAX_SIDE));

   always_comb begin
      state_in    = state_ff;
      div_run_in  = div_run_ff;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = DENW'(1);
      px_in       = px_ff;
      py_in       = py_ff;
      qx_in       = qx_ff;
      fac_in      = fac_ff;
      rw_in       = rw_ff;
      rh_in       = rh_ff;
      ax_y_in     = ax_y_ff;
      anum_in     = anum_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      crn_in      = crn_ff;
      ch_in       = ch_ff;
      ph_in       = ph_ff;
      colb_in     = colb_ff;
      rowb_in     = rowb_ff;
      xx_in       = xx_ff;
      yy_in       = yy_ff;
      n_in        = n_ff;
      iss_done_in = iss_done_ff;
      rd_valid_in = 1'b0;
      suma_in     = suma_ff;
      sumc_in     = sumc_ff;
      raw_in      = raw_ff;
      pix_in      = pix_ff;
      out_in      = out_ff;
      top_in      = top_ff;
      bot_in      = bot_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_addr    = AW'(req_word.pos_y) * AW'(MAX_SIDE) + AW'(req_word.pos_x);

      ap   = ax_y_ff ? py_ff : px_ff;
      as_c = ax_y_ff ? rh_ff : rw_ff;
      at_c = ax_y_ff ? th_c : tw_c;
      smax = as_c - SW'(1);
      ip   = quo[NUMW-1:FRAC_W];
      i0   = (ip > IPW'(smax)) ? smax : ip[SW-1:0];
      i0p  = {1'b0, i0} + (SW+1)'(1);
      i1   = (i0p < {1'b0, as_c}) ? i0p[SW-1:0] : smax;
      qy   = quo[SW-1:0];
      fmin = (qx_ff < qy) ? qx_ff : qy;
      cx   = crn_ff[0] ? x1_ff : x0_ff;
      cy   = crn_ff[1] ? y1_ff : y0_ff;

      pa  = pix_ff[0][{ch_ff, 3'b000} +: 8];
      pb  = pix_ff[1][{ch_ff, 3'b000} +: 8];
      pd  = pix_ff[2][{ch_ff, 3'b000} +: 8];
      pe  = pix_ff[3][{ch_ff, 3'b000} +: 8];
      dab = $signed({1'b0, pb}) - $signed({1'b0, pa});
      dde = $signed({1'b0, pe}) - $signed({1'b0, pd});
      txs = $signed({1'b0, tx_ff});
      tys = $signed({1'b0, ty_ff});
      pab = dab * txs;
      pde = dde * txs;
      dtb = bot_ff - top_ff;
      pv  = dtb * tys;
      v   = $signed({top_ff, 16'h0000}) + pv;
      vu  = v[43:0] + 44'h0_8000_0000;
      vr  = v[44] ? 12'd0 : vu[43:32];

      if (rd_valid_ff) begin
         raw_in     = ram_q;
         suma_in    = suma_ff + SUMAW'(ram_q[31:24]);
         sumc_in[0] = sumc_ff[0] + SUMCW'(ram_q[7:0] * ram_q[31:24]);
         sumc_in[1] = sumc_ff[1] + SUMCW'(ram_q[15:8] * ram_q[31:24]);
         sumc_in[2] = sumc_ff[2] + SUMCW'(ram_q[23:16] * ram_q[31:24]);
      end

      if (state_ff inside {ST_DIV_FX, ST_DIV_FY, ST_DIV_RW, ST_DIV_RH,
                           ST_DIV_AX, ST_DIV_A, ST_DIV_C}) begin
         if (!div_run_ff) begin
            div_start  = 1'b1;
            div_run_in = 1'b1;
         end else if (div_done) begin
            div_run_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_word.req_type == REQ_READ) begin
                  px_in    = req_word.pos_x;
                  py_in    = req_word.pos_y;
                  state_in = ST_DIV_FX;
               end else begin
                  ram_we = wr_in_range;
               end
            end
         end
         ST_DIV_FX: begin
            div_num = NUMW'(sw_c);
            div_den = DENW'(tw_c);
            if (div_done) begin
               qx_in    = quo[SW-1:0];
               state_in = ST_DIV_FY;
            end
         end
         ST_DIV_FY: begin
            div_num = NUMW'(sh_c);
            div_den = DENW'(th_c);
            if (div_done) begin
               if (fmin < SW'(2)) begin
                  fac_in   = SW'(1);
                  rw_in    = sw_c;
                  rh_in    = sh_c;
                  ax_y_in  = 1'b0;
                  state_in = ST_AX_PREP;
               end else begin
                  fac_in   = fmin;
                  state_in = ST_DIV_RW;
               end
            end
         end
         ST_DIV_RW: begin
            div_num = NUMW'(sw_c);
            div_den = DENW'(fac_ff);
            if (div_done) begin
               rw_in    = quo[SW-1:0];
               state_in = ST_DIV_RH;
            end
         end
         ST_DIV_RH: begin
            div_num = NUMW'(sh_c);
            div_den = DENW'(fac_ff);
            if (div_done) begin
               rh_in    = quo[SW-1:0];
               ax_y_in  = 1'b0;
               state_in = ST_AX_PREP;
            end
         end
         ST_AX_PREP: begin
            anum_in  = ANW'({ap, 1'b1}) * ANW'(as_c);
            state_in = ST_DIV_AX;
         end
         ST_DIV_AX: begin
            div_num = (anum_ff > ANW'(at_c)) ?
                      NUMW'({anum_ff - ANW'(at_c), 16'h0000}) : '0;
            div_den = DENW'({at_c, 1'b0});
            if (div_done) begin
               if (!ax_y_ff) begin
                  x0_in    = i0;
                  x1_in    = i1;
                  tx_in    = (i1 == i0) ? '0 : quo[FRAC_W-1:0];
                  ax_y_in  = 1'b1;
                  state_in = ST_AX_PREP;
               end else begin
                  y0_in    = i0;
                  y1_in    = i1;
                  ty_in    = (i1 == i0) ? '0 : quo[FRAC_W-1:0];
                  crn_in   = 2'd0;
                  state_in = ST_CRN_BASE;
               end
            end
         end
         ST_CRN_BASE: begin
            colb_in     = SW'(cx * fac_ff);
            rowb_in     = SW'(cy * fac_ff);
            n_in        = NSQW'(fac_ff) * NSQW'(fac_ff);
            xx_in       = '0;
            yy_in       = '0;
            iss_done_in = 1'b0;
            suma_in     = '0;
            sumc_in[0]  = '0;
            sumc_in[1]  = '0;
            sumc_in[2]  = '0;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            ram_addr = AW'(rowb_ff + yy_ff) * AW'(MAX_SIDE) + AW'(colb_ff + xx_ff);
            if (!iss_done_ff) begin
               ram_re      = 1'b1;
               rd_valid_in = 1'b1;
               if (xx_ff == fac_ff - SW'(1)) begin
                  xx_in = '0;
                  if (yy_ff == fac_ff - SW'(1)) begin
                     iss_done_in = 1'b1;
                  end else begin
                     yy_in = yy_ff + SW'(1);
                  end
               end else begin
                  xx_in = xx_ff + SW'(1);
               end
            end else if (!rd_valid_ff) begin
               if (fac_ff == SW'(1)) begin
                  pix_in[crn_ff] = raw_ff;
                  state_in       = ST_CRN_END;
               end else begin
                  state_in = ST_DIV_A;
               end
            end
         end
         ST_DIV_A: begin
            div_num = NUMW'(suma_ff);
            div_den = DENW'(n_ff);
            if (div_done) begin
               pix_in[crn_ff][31:24] = quo[7:0];
               if (suma_ff == '0) begin
                  pix_in[crn_ff][23:0] = '0;
                  state_in             = ST_CRN_END;
               end else begin
                  ch_in    = 2'd0;
                  state_in = ST_DIV_C;
               end
            end
         end
         ST_DIV_C: begin
            div_num = NUMW'(sumc_ff[ch_ff]);
            div_den = DENW'(suma_ff);
            if (div_done) begin
               pix_in[crn_ff][{ch_ff, 3'b000} +: 8] = quo[7:0];
               if (ch_ff == 2'd2) begin
                  state_in = ST_CRN_END;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         ST_CRN_END: begin
            if (crn_ff == 2'd3) begin
               ch_in    = 2'd0;
               ph_in    = 1'b0;
               state_in = ST_BLEND;
            end else begin
               crn_in   = crn_ff + 2'd1;
               state_in = ST_CRN_BASE;
            end
         end
         ST_BLEND: begin
            if (!ph_ff) begin
               top_in = $signed({3'b000, pa, 16'h0000}) + pab;
               bot_in = $signed({3'b000, pd, 16'h0000}) + pde;
               ph_in  = 1'b1;
            end else begin
               out_in[ch_ff] = (vr > 12'd255) ? 8'hff : vr[7:0];
               ph_in         = 1'b0;
               if (ch_ff == 2'd3) begin
                  state_in = ST_RESP;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         div_run_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
         src_w_ff    <= RST_SRC_WIDTH;
         src_h_ff    <= RST_SRC_HEIGHT;
         tgt_w_ff    <= RST_TGT_WIDTH;
         tgt_h_ff    <= RST_TGT_HEIGHT;
      end else begin
         state_ff    <= state_in;
         div_run_ff  <= div_run_in;
         rd_valid_ff <= rd_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff <= csr_data;
               CSR_SRC_HEIGHT: src_h_ff <= csr_data;
               CSR_TGT_WIDTH:  tgt_w_ff <= csr_data;
               CSR_TGT_HEIGHT: tgt_h_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      qx_ff       <= qx_in;
      fac_ff      <= fac_in;
      rw_ff       <= rw_in;
      rh_ff       <= rh_in;
      ax_y_ff     <= ax_y_in;
      anum_ff     <= anum_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      crn_ff      <= crn_in;
      ch_ff       <= ch_in;
      ph_ff       <= ph_in;
      colb_ff     <= colb_in;
      rowb_ff     <= rowb_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      n_ff        <= n_in;
      iss_done_ff <= iss_done_in;
      suma_ff     <= suma_in;
      sumc_ff     <= sumc_in;
      raw_ff      <= raw_in;
      pix_ff      <= pix_in;
      out_ff      <= out_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
   end

   awir_divider #(
      .NUMW (NUMW),
      .DENW (DENW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   awir_frame_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata ({req_word.in_alpha, req_word.in_blue, req_word.in_green,
               req_word.in_red}),
      .rdata (ram_q)
   );

`ifndef SYNTHESIS
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("frame store read and write in one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.req_type == REQ_READ) |=> busy)
      else $error("accepted request did not raise busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_run_ff)
      else $error("divider running while idle");
`endif

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for alpha_weighted_image_resampler: loads source
// images through pixel writes, sweeps the size registers across several
// settings and checks every resampled pixel against a bit-exact predictor.
// ----------------------------------------------------------------------------
module testbench;
   import awir_pkg::*;

   localparam int SIDE  = 512;
   localparam int LIMIT = 200000;

   class resample_scoreboard;
      bit [31:0]    pixels [0:SIDE*SIDE-1];
      int unsigned  sizes [4];
      awir_rsp_type pending_px [$];
      int           mismatches;
      int           results_seen;

      function new();
         sizes[0] = 32'(RST_SRC_WIDTH);
         sizes[1] = 32'(RST_SRC_HEIGHT);
         sizes[2] = 32'(RST_TGT_WIDTH);
         sizes[3] = 32'(RST_TGT_HEIGHT);
      endfunction

      function void set_size(int unsigned idx, int unsigned val);
         sizes[idx] = val;
      endfunction

      function int unsigned side_of(int unsigned v);
         if (v < 1) return 1;
         if (v > SIDE) return SIDE;
         return v;
      endfunction

      function bit [31:0] reduced_pixel(int unsigned x, int unsigned y, int unsigned fac);
         longint unsigned sum [4];
         longint unsigned a;
         bit [31:0] p, res;
         if (fac < 2) return pixels[y*SIDE + x];
         for (int c = 0; c < 4; c++) sum[c] = 0;
         for (int unsigned yy = 0; yy < fac; yy++)
            for (int unsigned xx = 0; xx < fac; xx++) begin
               p = pixels[(y*fac + yy)*SIDE + x*fac + xx];
               a = 64'(p[31:24]);
               sum[0] += 64'(p[7:0]) * a;
               sum[1] += 64'(p[15:8]) * a;
               sum[2] += 64'(p[23:16]) * a;
               sum[3] += a;
            end
         res = '0;
         res[31:24] = 8'(sum[3] / 64'(fac*fac));
         for (int c = 0; c < 3; c++)
            res[8*c +: 8] = (sum[3] != 0) ? 8'(sum[c] / sum[3]) : 8'd0;
         return res;
      endfunction

      function void locate(int unsigned p, int unsigned s, int unsigned t,
                           output int unsigned i0, output int unsigned i1,
                           output longint w);
         longint unsigned num, f, ip;
         num = 64'(2*p + 1) * 64'(s);
         f = 0;
         if (num > 64'(t)) f = ((num - 64'(t)) << 16) / (64'(t) * 64'd2);
         ip = f >> 16;
         if (ip > 64'(s - 1)) ip = 64'(s - 1);
         i0 = 32'(ip);
         i1 = (i0 + 1 < s) ? i0 + 1 : s - 1;
         if (i1 == i0)
            w = 0;
         else
            w = longint'(f - (ip << 16));
      endfunction

      function awir_rsp_type resample(int unsigned px, int unsigned py);
         int unsigned sw, sh, tw, th, fac, rw, rh, x0, x1, y0, y1;
         longint tx, ty, a, b, d, e, top, bot, v, r;
         bit [31:0] p00, p10, p01, p11, res;
         sw = side_of(sizes[0]);
         sh = side_of(sizes[1]);
         tw = side_of(sizes[2]);
         th = side_of(sizes[3]);
         fac = sw / tw;
         if (sh / th < fac) fac = sh / th;
         rw = sw;
         rh = sh;
         if (fac >= 2) begin
            rw = sw / fac;
            rh = sh / fac;
         end else begin
            fac = 1;
         end
         locate(px, rw, tw, x0, x1, tx);
         locate(py, rh, th, y0, y1, ty);
         p00 = reduced_pixel(x0, y0, fac);
         p10 = reduced_pixel(x1, y0, fac);
         p01 = reduced_pixel(x0, y1, fac);
         p11 = reduced_pixel(x1, y1, fac);
         for (int c = 0; c < 4; c++) begin
            a = longint'(p00[8*c +: 8]);
            b = longint'(p10[8*c +: 8]);
            d = longint'(p01[8*c +: 8]);
            e = longint'(p11[8*c +: 8]);
            top = a*65536 + (b - a)*tx;
            bot = d*65536 + (e - d)*tx;
            v = top*65536 + (bot - top)*ty;
            if (v < 0) v = 0;
            r = (v + (longint'(1) << 31)) >>> 32;
            if (r > 255) r = 255;
            res[8*c +: 8] = 8'(r);
         end
         return '{out_red: res[7:0], out_green: res[15:8],
                  out_blue: res[23:16], out_alpha: res[31:24]};
      endfunction

      function void note_word(awir_req_type w);
         if (w.req_type == REQ_WRITE)
            pixels[32'(w.pos_y)*SIDE + 32'(w.pos_x)] =
               {w.in_alpha, w.in_blue, w.in_green, w.in_red};
         else
            pending_px = {pending_px, resample(32'(w.pos_x), 32'(w.pos_y))};
      endfunction

      function void check_word(awir_rsp_type got);
         awir_rsp_type exp_px;
         results_seen++;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
         end
         exp_px = pending_px.pop_front();
         if (got !== exp_px) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                        exp_px.out_red, exp_px.out_green, exp_px.out_blue, exp_px.out_alpha,
                        got.out_red, got.out_green, got.out_blue, got.out_alpha);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   awir_req_type         req_word;
   logic                 rsp_valid;
   awir_rsp_type         rsp_word;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   resample_scoreboard sb = new();
   bit   loaded [0:SIDE*SIDE-1];
   int   words_sent;
   int   idle_pct;
   int   stall_cycles = 0;
   int   phases_run;

   alpha_weighted_image_resampler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_word(rsp_word);
         if (start && !busy) sb.note_word(req_word);
         if (csr_valid && csr_ready) sb.set_size(32'(csr_index), 32'(csr_data));
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= LIMIT) begin
            $display("alpha_weighted_image_resampler test failed");
            $finish;
         end
      end
   end

   task automatic send_word(awir_req_type w);
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
      idle_pct = (words_sent < 700) ? 13 : (words_sent < 1400) ? 73 : 0;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic write_pixel(int unsigned x, int unsigned y, int alpha_sel);
      awir_req_type w;
      w.req_type = REQ_WRITE;
      w.pos_x    = POS_W'(x);
      w.pos_y    = POS_W'(y);
      w.in_red   = CH_W'($urandom);
      w.in_green = CH_W'($urandom);
      w.in_blue  = CH_W'($urandom);
      case ($urandom_range(3))
         0: w.in_alpha = 8'd0;
         1: w.in_alpha = 8'd255;
         default: w.in_alpha = CH_W'($urandom);
      endcase
      if (alpha_sel >= 0) w.in_alpha = CH_W'(alpha_sel);
      loaded[y*SIDE + x] = 1'b1;
      send_word(w);
   endtask

   task automatic request_pixel(int unsigned x, int unsigned y);
      awir_req_type w;
      w = '0;
      w.req_type = REQ_READ;
      w.pos_x    = POS_W'(x);
      w.pos_y    = POS_W'(y);
      w.in_red   = CH_W'($urandom);
      w.in_green = CH_W'($urandom);
      w.in_blue  = CH_W'($urandom);
      w.in_alpha = CH_W'($urandom);
      send_word(w);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_index <= idx;
      csr_data  <= CFG_W'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // program sizes and make sure every source pixel that can be read is loaded
   task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
      int unsigned ew, eh;
      drain();
      write_size(CSR_SRC_WIDTH, sw);
      write_size(CSR_SRC_HEIGHT, sh);
      write_size(CSR_TGT_WIDTH, tw);
      write_size(CSR_TGT_HEIGHT, th);
      phases_run++;
      ew = sb.side_of(32'(CFG_W'(sw)));
      eh = sb.side_of(32'(CFG_W'(sh)));
      for (int unsigned y = 0; y < eh; y++)
         for (int unsigned x = 0; x < ew; x++)
            if (!loaded[y*SIDE + x]) write_pixel(x, y, -1);
   endtask

   task automatic mixed_traffic(int unsigned nreq);
      int unsigned ew, eh;
      ew = sb.side_of(sb.sizes[0]);
      eh = sb.side_of(sb.sizes[1]);
      for (int unsigned i = 0; i < nreq; i++) begin
         if ($urandom_range(9) < 3)
            write_pixel($urandom_range(ew - 1), $urandom_range(eh - 1), -1);
         if ($urandom_range(9) == 0)
            write_pixel($urandom_range(SIDE - 1), $urandom_range(SIDE - 1), -1);
         if ($urandom_range(3) == 0)
            request_pixel($urandom_range(SIDE - 1), $urandom_range(SIDE - 1));
         else
            request_pixel($urandom_range(sb.side_of(sb.sizes[2]) - 1),
                          $urandom_range(sb.side_of(sb.sizes[3]) - 1));
         if ($urandom_range(49) == 0) drain();
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_SRC_WIDTH;
      csr_data   = '0;
      words_sent = 0;
      idle_pct   = 13;
      phases_run = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x box reduction, one block fully transparent
      set_sizes(8, 8, 4, 4);
      write_pixel(0, 0, 0);
      write_pixel(1, 0, 0);
      write_pixel(0, 1, 0);
      write_pixel(1, 1, 0);
      request_pixel(0, 0);
      request_pixel(3, 3);
      request_pixel(511, 511);
      request_pixel(1, 2);
      // widest and tallest source, out of range sizes saturate
      set_sizes(512, 1, 512, 1);
      request_pixel(0, 0);
      request_pixel(511, 0);
      request_pixel(255, 511);
      set_sizes(0, 1023, 0, 1023);
      request_pixel(0, 0);
      request_pixel(0, 511);
      set_sizes(1, 512, 1, 512);
      request_pixel(0, 300);
      // upsampling and a large block
      set_sizes(5, 7, 9, 13);
      request_pixel(0, 0);
      request_pixel(8, 12);
      request_pixel(4, 6);
      set_sizes(20, 20, 2, 2);
      request_pixel(0, 0);
      request_pixel(1, 1);
      request_pixel(2, 5);

      for (int p = 0; p < 18; p++) begin
         set_sizes($urandom_range(1, 24), $urandom_range(1, 24),
                   $urandom_range(1, 24), $urandom_range(1, 24));
         mixed_traffic(30);
      end
      set_sizes(1023, 1, 1, 1023);
      mixed_traffic(10);

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d words over %0d size settings, %0d resampled pixels checked",
               words_sent, phases_run, sb.results_seen);
      $display("%0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_px.size() == 0)
         $display("alpha_weighted_image_resampler test passed");
      else
         $display("alpha_weighted_image_resampler test failed");
      $finish;
   end

endmodule
